@@ sv/vsa_pkg.sv @@
// Shared types and codes for the variable store ALU.
`timescale 1ns / 1ps

package vsa_pkg;

  typedef enum logic [3:0] {
    MODE_DECLARE = 4'd0,
    MODE_MOV     = 4'd1,
    MODE_XCHG    = 4'd2,
    MODE_ADD     = 4'd3,
    MODE_SUB     = 4'd4,
    MODE_MUL     = 4'd5,
    MODE_DIV     = 4'd6,
    MODE_AND     = 4'd7,
    MODE_OR      = 4'd8,
    MODE_XOR     = 4'd9,
    MODE_INC     = 4'd10,
    MODE_DEC     = 4'd11
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NODEST  = 2'd1,
    ST_NOSRC   = 2'd2,
    ST_DIVZERO = 2'd3
  } status_t;

  // write port control into the store
  typedef struct packed {
    logic en;
    logic set_decl;
  } wr_ctl_t;

  // request into the iterative multiply/divide unit
  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;

endpackage

@@ sv/variable_store_alu.sv @@
// Top level: instruction sequencer over the variable store and the multiply/divide unit.
// Each instruction reads its operands from the store, then executes and writes back;
//   XCHG holds the block for a second write, and MUL and DIV wait on the muldiv unit.
// A new instruction is taken only in idle, after the last one has finished; a stalled
//   output register holds the execute step.
// Reset clears the declared flags and the control state; stored values are not cleared.
`timescale 1ns / 1ps

module variable_store_alu import vsa_pkg::*; #(
  parameter int NUM_VARS  = 16,
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  mode,
  input  logic [3:0]  dest_index,
  input  logic [3:0]  src_index,
  input  logic [31:0] immediate,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] result_value
);

  localparam int AW = $clog2(NUM_VARS);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_XCHG, S_WAIT} state_t;

  state_t               state;
  logic [3:0]           mode_q;
  logic [AW-1:0]        d_addr;
  logic [AW-1:0]        s_addr;
  logic                 d_ok_q;
  logic [WORD_BITS-1:0] imm_q;
  logic [1:0]           status_q;
  logic [31:0]          result_q;

  logic                 rd_en;
  logic [WORD_BITS-1:0] a_val;
  logic [WORD_BITS-1:0] b_val;
  logic                 decl_a;
  logic                 decl_b;
  wr_ctl_t              wr;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  md_req_t              md_req;
  logic                 md_done;
  logic [WORD_BITS-1:0] md_result;

  logic                 out_free;
  logic                 out_load;
  status_t              ex_status;
  logic [WORD_BITS-1:0] ex_val;
  logic [WORD_BITS-1:0] alu_val;
  logic                 ex_write;
  logic                 ex_decl;
  logic                 ex_md;
  logic                 ex_xchg;

  assign in_stall     = (state != S_IDLE);
  assign rd_en        = in_valid && (state == S_IDLE);
  assign out_free     = !out_valid || !out_stall;
  assign status       = status_q;
  assign result_value = result_q;

  vsa_store #(
    .NUM_VARS  (NUM_VARS),
    .WORD_BITS (WORD_BITS),
    .AW        (AW)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (rd_en),
    .rd_addr_a (AW'(dest_index)),
    .rd_ok_a   (32'(dest_index) < 32'(NUM_VARS)),
    .rd_addr_b (AW'(src_index)),
    .rd_ok_b   (32'(src_index) < 32'(NUM_VARS)),
    .rd_data_a (a_val),
    .rd_data_b (b_val),
    .rd_decl_a (decl_a),
    .rd_decl_b (decl_b),
    .wr        (wr),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  vsa_muldiv #(
    .WORD_BITS (WORD_BITS)
  ) u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .req    (md_req),
    .op_a   (a_val),
    .op_b   (b_val),
    .done   (md_done),
    .result (md_result)
  );

  // combinational two-operand ops
  always_comb begin
    case (mode_t'(mode_q))
      MODE_MOV, MODE_XCHG: alu_val = b_val;
      MODE_ADD:            alu_val = a_val + b_val;
      MODE_SUB:            alu_val = a_val - b_val;
      MODE_AND:            alu_val = a_val & b_val;
      MODE_OR:             alu_val = a_val | b_val;
      default:             alu_val = a_val ^ b_val;
    endcase
  end

  // checks in order: destination, source, divisor
  always_comb begin
    ex_status = ST_OK;
    ex_val    = '0;
    ex_write  = 1'b0;
    ex_decl   = 1'b0;
    ex_md     = 1'b0;
    ex_xchg   = 1'b0;
    case (mode_t'(mode_q))
      MODE_DECLARE: begin
        if (!d_ok_q) begin
          ex_status = ST_NODEST;
        end else begin
          ex_val   = imm_q;
          ex_write = 1'b1;
          ex_decl  = 1'b1;
        end
      end
      MODE_INC, MODE_DEC: begin
        if (!decl_a) begin
          ex_status = ST_NODEST;
        end else begin
          ex_val   = (mode_q == MODE_INC) ? a_val + 1'b1 : a_val - 1'b1;
          ex_write = 1'b1;
        end
      end
      MODE_MOV, MODE_XCHG, MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV,
      MODE_AND, MODE_OR, MODE_XOR: begin
        if (!decl_a) begin
          ex_status = ST_NODEST;
        end else if (!decl_b) begin
          ex_status = ST_NOSRC;
        end else if (mode_q == MODE_DIV && b_val == '0) begin
          ex_status = ST_DIVZERO;
        end else if (mode_q == MODE_MUL || mode_q == MODE_DIV) begin
          ex_md = 1'b1;
        end else begin
          ex_val   = alu_val;
          ex_write = 1'b1;
          ex_xchg  = (mode_q == MODE_XCHG);
        end
      end
      default: ex_status = ST_OK;
    endcase
  end

  assign md_req.start  = (state == S_EXEC) && out_free && ex_md;
  assign md_req.is_div = (mode_q == MODE_DIV);

  // output register loads a new transaction
  assign out_load = ((state == S_EXEC) && out_free && !ex_md) ||
                    ((state == S_WAIT) && md_done);

  always_comb begin
    wr      = '0;
    wr_addr = d_addr;
    wr_data = ex_val;
    case (state)
      S_EXEC: begin
        wr.en       = out_free && ex_write;
        wr.set_decl = ex_decl;
      end
      S_XCHG: begin
        // second half of exchange: old destination value into source
        wr.en   = 1'b1;
        wr_addr = s_addr;
        wr_data = a_val;
      end
      S_WAIT: begin
        wr.en   = md_done;
        wr_data = md_result;
      end
      default: wr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode_q <= mode;
            d_addr <= AW'(dest_index);
            s_addr <= AW'(src_index);
            d_ok_q <= 32'(dest_index) < 32'(NUM_VARS);
            imm_q  <= WORD_BITS'(immediate);
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            if (ex_md) begin
              state <= S_WAIT;
            end else begin
              status_q  <= ex_status;
              result_q  <= 32'(ex_val);
              state     <= ex_xchg ? S_XCHG : S_IDLE;
            end
          end
        end
        S_XCHG: begin
          state <= S_IDLE;
        end
        S_WAIT: begin
          if (md_done) begin
            status_q  <= ST_OK;
            result_q  <= 32'(md_result);
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_md_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    md_done |-> state == S_WAIT)
    else $error("mul/div completion outside wait state");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> result_value == '0)
    else $error("error transaction carries nonzero result");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> state != S_IDLE)
    else $error("store write while idle");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> state == S_EXEC)
    else $error("accepted transaction did not enter execute");

endmodule

@@ sv/vsa_store.sv @@
// Variable store: value memory with two registered read ports and declared flags.
`timescale 1ns / 1ps

module vsa_store import vsa_pkg::*; #(
  parameter int NUM_VARS  = 16,
  parameter int WORD_BITS = 32,
  parameter int AW        = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr_a,
  input  logic                 rd_ok_a,
  input  logic [AW-1:0]        rd_addr_b,
  input  logic                 rd_ok_b,
  output logic [WORD_BITS-1:0] rd_data_a,
  output logic [WORD_BITS-1:0] rd_data_b,
  output logic                 rd_decl_a,
  output logic                 rd_decl_b,
  input  wr_ctl_t              wr,
  input  logic [AW-1:0]        wr_addr,
  input  logic [WORD_BITS-1:0] wr_data
);

  logic [WORD_BITS-1:0] mem [NUM_VARS];
  logic [NUM_VARS-1:0]  decl;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

  // out-of-range indexes never count as declared
  always_ff @(posedge clk) begin
    if (rst) begin
      decl      <= '0;
      rd_decl_a <= 1'b0;
      rd_decl_b <= 1'b0;
    end else begin
      if (wr.en && wr.set_decl) begin
        decl[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_decl_a <= rd_ok_a && decl[rd_addr_a];
        rd_decl_b <= rd_ok_b && decl[rd_addr_b];
      end
    end
  end

endmodule

@@ sv/vsa_muldiv.sv @@
// Iterative multiplier (16-bit digits) and restoring divider (one bit per cycle).
`timescale 1ns / 1ps

module vsa_muldiv import vsa_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  md_req_t              req,
  input  logic [WORD_BITS-1:0] op_a,
  input  logic [WORD_BITS-1:0] op_b,
  output logic                 done,
  output logic [WORD_BITS-1:0] result
);

  localparam int DG = 16;
  localparam int CW = $clog2(WORD_BITS);

  typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} md_state_t;

  md_state_t            md_state;
  logic [WORD_BITS-1:0] acc;     // product, or partial remainder
  logic [WORD_BITS-1:0] a_sh;    // shifted multiplicand, or dividend/quotient
  logic [WORD_BITS-1:0] b_rem;   // remaining multiplier, or divisor
  logic [CW-1:0]        cnt;

  logic [DG-1:0]        b_dig;
  logic [WORD_BITS-1:0] mul_pp;
  logic [WORD_BITS:0]   rem_sh;
  logic [WORD_BITS:0]   diff;
  logic                 ge;

  assign b_dig  = DG'(b_rem);
  assign mul_pp = WORD_BITS'(a_sh * b_dig);
  assign rem_sh = {acc, a_sh[WORD_BITS-1]};
  assign diff   = rem_sh - {1'b0, b_rem};
  assign ge     = !diff[WORD_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      md_state <= MD_IDLE;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (md_state)
        MD_IDLE: begin
          if (req.start) begin
            a_sh  <= op_a;
            b_rem <= op_b;
            acc   <= '0;
            cnt   <= '0;
            md_state <= req.is_div ? MD_DIV : MD_MUL;
          end
        end
        MD_MUL: begin
          if (b_rem == '0) begin
            result   <= acc;
            done     <= 1'b1;
            md_state <= MD_IDLE;
          end else begin
            acc   <= acc + mul_pp;
            a_sh  <= a_sh << DG;
            b_rem <= b_rem >> DG;
          end
        end
        MD_DIV: begin
          acc  <= ge ? diff[WORD_BITS-1:0] : rem_sh[WORD_BITS-1:0];
          a_sh <= {a_sh[WORD_BITS-2:0], ge};
          cnt  <= cnt + 1'b1;
          if (cnt == CW'(WORD_BITS - 1)) begin
            result   <= {a_sh[WORD_BITS-2:0], ge};
            done     <= 1'b1;
            md_state <= MD_IDLE;
          end
        end
        default: md_state <= MD_IDLE;
      endcase
    end
  end

endmodule
